FILE: hdl/heap_guard_and_refresh_scheduler_assert.svh
// Assertion macros for the heap guard / refresh scheduler.
// Each expects clk and rst_n in scope.
`ifndef HEAP_GUARD_AND_REFRESH_SCHEDULER_ASSERT_SVH
`define HEAP_GUARD_AND_REFRESH_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define HGRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hgrs: same-cycle check failed");

// Next-cycle implication.
`define HGRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hgrs: next-cycle check failed");

`endif

FILE: hdl/hgrs_pkg.sv
package hgrs_pkg;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        tx_idle;
    logic [31:0] largest_free_bytes;
    logic        mqtt_active;
  } in_item_t;

  typedef struct packed {
    logic reboot_request;
    logic stop_mqtt;
    logic refresh_crypto;
    logic send_arp;
  } out_item_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_FLOOR_KB       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARM_DELAY_MS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REBOOT_GAP_MS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_INTERVAL_MS = 3'd4;

  localparam logic [21:0] RST_HEAP_FLOOR_KB       = 22'd0;
  localparam logic [31:0] RST_ARM_DELAY_MS        = 32'd7200000;   // 2 h
  localparam logic [30:0] RST_REBOOT_GAP_MS       = 31'd21600000;  // 6 h
  localparam logic [7:0]  RST_CONFIRM_COUNT       = 8'd3;
  localparam logic [30:0] RST_REFRESH_INTERVAL_MS = 31'd86400000;  // 24 h

  localparam logic [7:0] STREAK_MAX = 8'hFF;

endpackage

FILE: hdl/hgrs_if.sv
interface hgrs_in_if;
  import hgrs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface hgrs_out_if;
  import hgrs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/heap_guard_and_refresh_scheduler.sv
// Heap guard and refresh scheduler. Every tick item accepted on in_ch gives
// exactly one result item on out_ch. A tick is first captured in an input
// register; the guard and refresh decisions are then formed by one level of
// compare and count logic and stored in the result register, while the
// schedule state (below-floor streak, last reboot and last refresh time) is
// updated in the same edge. Throughput is one item per clock: the input
// register refills while the result register is handed on, so a stall only
// holds the block when both registers are full. Registers are written through
// cfg_* and take effect from the next tick processed.
`include "heap_guard_and_refresh_scheduler_assert.svh"

module heap_guard_and_refresh_scheduler (
  input  logic                                  clk,
  input  logic                                  rst_n,
  hgrs_in_if.sink                               in_ch,
  hgrs_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  logic [hgrs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hgrs_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import hgrs_pkg::*;

  // configuration
  logic [21:0] heap_floor_kb_r;
  logic [31:0] arm_delay_ms_r;
  logic [30:0] reboot_gap_ms_r;
  logic [7:0]  confirm_count_r;
  logic [30:0] refresh_interval_ms_r;

  // schedule state
  logic [7:0]  streak_r, streak_nxt;
  logic [31:0] last_reboot_r, last_reboot_nxt;
  logic        reboot_valid_r, reboot_valid_nxt;
  logic [31:0] last_refresh_r, last_refresh_nxt;

  // pipeline
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;
  logic      advance;

  // decision terms
  logic [31:0] reboot_diff, refresh_diff;
  logic        in_gap, refresh_due, healthy, armed;
  logic [7:0]  streak_inc;

  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.payload = out_item_r;

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_floor_kb_r       <= RST_HEAP_FLOOR_KB;
      arm_delay_ms_r        <= RST_ARM_DELAY_MS;
      reboot_gap_ms_r       <= RST_REBOOT_GAP_MS;
      confirm_count_r       <= RST_CONFIRM_COUNT;
      refresh_interval_ms_r <= RST_REFRESH_INTERVAL_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEAP_FLOOR_KB:       heap_floor_kb_r       <= cfg_wdata[21:0];
        CFG_ARM_DELAY_MS:        arm_delay_ms_r        <= cfg_wdata;
        CFG_REBOOT_GAP_MS:       reboot_gap_ms_r       <= cfg_wdata[30:0];
        CFG_CONFIRM_COUNT:       confirm_count_r       <= cfg_wdata[7:0];
        CFG_REFRESH_INTERVAL_MS: refresh_interval_ms_r <= cfg_wdata[30:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // Wrapped differences read as signed; the limits are never negative, so a
  // negative difference is always below them.
  assign reboot_diff  = s1_item_r.now_ms - last_reboot_r;
  assign refresh_diff = s1_item_r.now_ms - last_refresh_r;
  assign in_gap       = reboot_valid_r &&
                        (reboot_diff[31] || (reboot_diff[30:0] < reboot_gap_ms_r));
  assign refresh_due  = !refresh_diff[31] && (refresh_diff[30:0] >= refresh_interval_ms_r);
  assign healthy      = s1_item_r.largest_free_bytes >= {heap_floor_kb_r, 10'd0};
  assign armed        = !(s1_item_r.now_ms < arm_delay_ms_r);
  assign streak_inc   = (streak_r == STREAK_MAX) ? STREAK_MAX : streak_r + 8'd1;

  always_comb begin
    streak_nxt       = streak_r;
    last_reboot_nxt  = last_reboot_r;
    reboot_valid_nxt = reboot_valid_r;
    last_refresh_nxt = last_refresh_r;
    out_item_nxt     = '0;

    // heap guard: off with a zero floor, streak kept
    if (heap_floor_kb_r != '0) begin
      if (!armed) begin
        streak_nxt = '0;
      end else if (!in_gap && s1_item_r.tx_idle) begin
        if (healthy) begin
          streak_nxt = '0;
        end else begin
          streak_nxt = streak_inc;
          if (streak_inc >= confirm_count_r) begin
            out_item_nxt.reboot_request = 1'b1;
            last_reboot_nxt             = s1_item_r.now_ms;
            reboot_valid_nxt            = 1'b1;
          end
        end
      end
    end

    // refresh chores wait for an idle tick once due
    if (refresh_due && s1_item_r.tx_idle) begin
      out_item_nxt.refresh_crypto = 1'b1;
      out_item_nxt.send_arp       = 1'b1;
      out_item_nxt.stop_mqtt      = s1_item_r.mqtt_active;
      last_refresh_nxt            = s1_item_r.now_ms;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r <= in_ch.payload;
    end
  end

  // result register and schedule state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      streak_r       <= '0;
      last_reboot_r  <= '0;
      reboot_valid_r <= 1'b0;
      last_refresh_r <= '0;
    end else begin
      if (advance) begin
        out_valid_r    <= 1'b1;
        streak_r       <= streak_nxt;
        last_reboot_r  <= last_reboot_nxt;
        reboot_valid_r <= reboot_valid_nxt;
        last_refresh_r <= last_refresh_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  // checks
  `HGRS_ASSERT_NOW(a_chores_paired, out_valid_r, (out_item_r.refresh_crypto == out_item_r.send_arp) && (!out_item_r.stop_mqtt || out_item_r.refresh_crypto))
  `HGRS_ASSERT_NEXT(a_refresh_time, advance && out_item_nxt.refresh_crypto, last_refresh_r == $past(s1_item_r.now_ms))
  `HGRS_ASSERT_NEXT(a_reboot_recorded, advance && out_item_nxt.reboot_request, reboot_valid_r && (last_reboot_r == $past(s1_item_r.now_ms)))
  `HGRS_ASSERT_NEXT(a_guard_off_streak, advance && (heap_floor_kb_r == '0), $stable(streak_r))

endmodule
